FILE: design/dda_grid_ray_cast_assert.svh
// assertion macros used by the ray caster back end
`ifndef DDA_GRID_RAY_CAST_ASSERT_SVH
`define DDA_GRID_RAY_CAST_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DGRC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dgrc check failed");

// next-cycle implication, checked out of reset
`define DGRC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dgrc check failed");

`endif

FILE: design/dgrc_pkg.sv
// types and constants of the dda grid ray caster
`timescale 1ns / 1ps
package dgrc_pkg;
   localparam int FRAC_BITS = 16;
   localparam int MAP_BITS = 6;
   localparam int ADDR_W = 2 * MAP_BITS;
   localparam int POS_W = MAP_BITS + FRAC_BITS;
   localparam int DIR_W = 16;
   localparam int SIDE_W = FRAC_BITS + 15;
   localparam int DIST_W = FRAC_BITS + 7;
   localparam int OFF_W = 16;
   localparam int LIMIT_W = 8;
   localparam int VALUE_W = 8;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 56;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd128;
   localparam logic [SIDE_W-1:0] SIDE_CAP = {SIDE_W{1'b1}};
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_CAST  = 1'b1
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [POS_W-1:0]          pos_x;
      logic [POS_W-1:0]          pos_y;
      logic signed [DIR_W-1:0]   dir_x;
      logic signed [DIR_W-1:0]   dir_y;
      logic [MAP_BITS-1:0]       col;
      logic [MAP_BITS-1:0]       row;
      logic [VALUE_W-1:0]        value;
   } item_type;

   // queue head seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic              start;
      logic [DIR_W-1:0]  mag;
   } recip_req_type;

   typedef struct packed {
      logic              done;
      logic [SIDE_W-1:0] quot;
   } recip_rsp_type;
endpackage

FILE: design/dda_grid_ray_cast.sv
// top level of the dda grid ray caster
//
//   channel | dir | fields
//   req_*   | in  | tuser opcode, tdata pos/dir/cell write fields
//   rsp_*   | out | tuser hit_found, tdata cell, side, distance, offset
//   csr_*   | in  | step_limit write
//
// a cell write is done by the back end straight from the idle state
// a cast runs two serial reciprocals (31 quotient bits each, then a done
// strobe), one multiply state, then a step state and a map memory read per
// grid step, and an offset state on a hit; a step that leaves the map goes to done
// after reset a clearing pass zeroes all 4096 map cells; no item is taken
// a two-entry queue lets the input side keep accepting while a result waits
`timescale 1ns / 1ps
module dda_grid_ray_cast
   import dgrc_pkg::*;
#(
   parameter int CELL_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pos_x, pos_y, dir_x, dir_y, cell_col, cell_row, cell_value
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hit_col, hit_row, hit_side, perp_distance, wall_offset, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // hit_found
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [LIMIT_W-1:0]    csr_wdata
);
   queue_head_type q_head;
   logic           q_pop;
   logic           clearing;
   recip_req_type  rreq;
   recip_rsp_type  rrsp;

   dgrc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .hold       (clearing),
      .q_head     (q_head),
      .q_pop      (q_pop)
   );

   dgrc_recip u_recip (
      .clock (clock),
      .reset (reset),
      .rreq  (rreq),
      .rrsp  (rrsp)
   );

   dgrc_back #(
      .CELL_BITS (CELL_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .rreq       (rreq),
      .rrsp       (rrsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );
endmodule

FILE: design/dgrc_front.sv
// front end: takes items in, decodes the opcode and queues them
`timescale 1ns / 1ps
module dgrc_front
   import dgrc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  hold,
   output queue_head_type        q_head,
   input  logic                  q_pop
);
   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   dec;

   // decode the incoming item
   always_comb begin
      dec.op = (req_tuser == OP_CAST) ? OP_CAST : OP_WRITE;
      dec.pos_x = req_tdata[21:0];
      dec.pos_y = req_tdata[43:22];
      dec.dir_x = req_tdata[59:44];
      dec.dir_y = req_tdata[75:60];
      dec.col = req_tdata[81:76];
      dec.row = req_tdata[87:82];
      dec.value = req_tdata[95:88];
   end

   assign req_tready = (count_ff != 2'd2) && !hold;
   assign push = req_tvalid && req_tready;
   assign q_head.valid = (count_ff != 2'd0);
   assign q_head.item = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end
endmodule

FILE: design/dgrc_recip.sv
// serial reciprocal: 2^30 / magnitude, one quotient bit a cycle
`timescale 1ns / 1ps
module dgrc_recip
   import dgrc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  recip_req_type rreq,
   output recip_rsp_type rrsp
);
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [DIR_W:0]    rem_ff, rem_in;
   logic [SIDE_W-1:0] quo_ff, quo_in;
   logic [DIR_W-1:0]  mag_ff, mag_in;
   logic [DIR_W:0]    trial;
   logic              ge;

   // load on start, else one restoring step; a zero magnitude gives all ones
   always_comb begin
      trial = {rem_ff[DIR_W-1:0], (cnt_ff == 5'(SIDE_W - 1))};
      ge = (trial >= {1'b0, mag_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      mag_in = mag_ff;
      if (rreq.start) begin
         busy_in = 1'b1;
         cnt_in = 5'(SIDE_W - 1);
         rem_in = '0;
         quo_in = '0;
         mag_in = rreq.mag;
      end else if (busy_ff) begin
         rem_in = ge ? (trial - {1'b0, mag_ff}) : trial;
         quo_in = {quo_ff[SIDE_W-2:0], ge};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      mag_ff <= mag_in;
   end

   assign rrsp.done = done_ff;
   assign rrsp.quot = quo_ff;
endmodule

FILE: design/dgrc_back.sv
// back end: map memory, dda walk sequencer and result register
`timescale 1ns / 1ps
module dgrc_back
   import dgrc_pkg::*;
#(
   parameter int CELL_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [LIMIT_W-1:0]    csr_wdata,
   input  queue_head_type        q_head,
   output logic                  q_pop,
   output logic                  clearing,
   output recip_req_type         rreq,
   input  recip_rsp_type         rrsp,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);
   `include "dda_grid_ray_cast_assert.svh"

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_DIV_X = 9'b000000100,
      ST_DIV_Y = 9'b000001000,
      ST_SIDE  = 9'b000010000,
      ST_STEP  = 9'b000100000,
      ST_CHECK = 9'b001000000,
      ST_OFFS  = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   localparam int DEPTH = 1 << ADDR_W;
   localparam logic [MAP_BITS-1:0] EDGE_HI = {MAP_BITS{1'b1}};

   logic [CELL_BITS-1:0] map_mem [DEPTH];

   state_type            state_ff, state_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   item_type             it_ff, it_in;
   logic [SIDE_W-1:0]    ddx_ff, ddx_in, ddy_ff, ddy_in;
   logic [SIDE_W-1:0]    sx_ff, sx_in, sy_ff, sy_in;
   logic [SIDE_W-1:0]    dist_ff, dist_in;
   logic [MAP_BITS-1:0]  mx_ff, mx_in, my_ff, my_in;
   logic                 side_ff, side_in;
   logic                 hit_ff, hit_in;
   logic [LIMIT_W-1:0]   cnt_ff, cnt_in;
   logic [29:0]          oprod_ff, oprod_in;
   logic [CELL_BITS-1:0] rd_ff;
   logic                 ovalid_ff, ovalid_in;
   logic [RSP_DATA_W-1:0] odata_ff, odata_in;
   logic                 ohit_ff, ohit_in;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr, rd_addr;
   logic [CELL_BITS-1:0] wr_data;
   logic [FRAC_BITS:0]   fx, fy;
   logic [47:0]          px, py;
   logic                 go_x;
   logic [SIDE_W:0]      sum_x, sum_y;
   logic                 leave;
   logic [MAP_BITS-1:0]  nx, ny;
   logic signed [DIR_W-1:0] odir;
   logic [FRAC_BITS-1:0] opos;
   logic signed [47:0]   oprod_full;
   logic [29:0]          osum;
   logic [DIST_W-1:0]    dist_sat;
   logic                 out_free;

   assign clearing = (state_ff == ST_CLEAR);
   assign out_free = !ovalid_ff || rsp_tready;

   // first boundary distances from the fractional start position
   always_comb begin
      fx = it_ff.dir_x[DIR_W-1] ? {1'b0, it_ff.pos_x[FRAC_BITS-1:0]}
         : (17'h10000 - {1'b0, it_ff.pos_x[FRAC_BITS-1:0]});
      fy = it_ff.dir_y[DIR_W-1] ? {1'b0, it_ff.pos_y[FRAC_BITS-1:0]}
         : (17'h10000 - {1'b0, it_ff.pos_y[FRAC_BITS-1:0]});
      px = 48'(fx) * 48'(ddx_ff);
      py = 48'(fy) * 48'(ddy_ff);
   end

   // pick the nearer boundary and the neighbor cell
   always_comb begin
      go_x = (sx_ff < sy_ff);
      sum_x = {1'b0, sx_ff} + {1'b0, ddx_ff};
      sum_y = {1'b0, sy_ff} + {1'b0, ddy_ff};
      nx = it_ff.dir_x[DIR_W-1] ? (mx_ff - 6'd1) : (mx_ff + 6'd1);
      ny = it_ff.dir_y[DIR_W-1] ? (my_ff - 6'd1) : (my_ff + 6'd1);
      if (go_x) begin
         leave = it_ff.dir_x[DIR_W-1] ? (mx_ff == '0) : (mx_ff == EDGE_HI);
      end else begin
         leave = it_ff.dir_y[DIR_W-1] ? (my_ff == '0) : (my_ff == EDGE_HI);
      end
   end

   // wall offset along the other axis
   always_comb begin
      odir = side_ff ? it_ff.dir_x : it_ff.dir_y;
      opos = side_ff ? it_ff.pos_x[FRAC_BITS-1:0] : it_ff.pos_y[FRAC_BITS-1:0];
      oprod_full = $signed({17'd0, dist_ff}) * 48'(odir);
      osum = {opos, 14'd0} + oprod_ff;
      dist_sat = (dist_ff > SIDE_W'(DIST_MAX)) ? DIST_MAX : dist_ff[DIST_W-1:0];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      limit_in = csr_we ? csr_wdata : limit_ff;
      clr_in = clr_ff;
      it_in = it_ff;
      ddx_in = ddx_ff;
      ddy_in = ddy_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      dist_in = dist_ff;
      mx_in = mx_ff;
      my_in = my_ff;
      side_in = side_ff;
      hit_in = hit_ff;
      cnt_in = cnt_ff;
      oprod_in = oprod_ff;
      ovalid_in = (ovalid_ff && !rsp_tready);
      odata_in = odata_ff;
      ohit_in = ohit_ff;
      q_pop = 1'b0;
      wr_en = 1'b0;
      wr_addr = clr_ff;
      wr_data = '0;
      rd_addr = {my_ff, mx_ff};
      rreq.start = 1'b0;
      rreq.mag = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_head.valid) begin
               q_pop = 1'b1;
               if (q_head.item.op == OP_WRITE) begin
                  wr_en = 1'b1;
                  wr_addr = {q_head.item.row, q_head.item.col};
                  wr_data = CELL_BITS'(q_head.item.value);
               end else begin
                  it_in = q_head.item;
                  mx_in = q_head.item.pos_x[POS_W-1:FRAC_BITS];
                  my_in = q_head.item.pos_y[POS_W-1:FRAC_BITS];
                  side_in = 1'b0;
                  hit_in = 1'b0;
                  cnt_in = '0;
                  dist_in = '0;
                  rreq.start = 1'b1;
                  rreq.mag = q_head.item.dir_x[DIR_W-1] ? DIR_W'(-q_head.item.dir_x)
                     : q_head.item.dir_x;
                  state_in = ST_DIV_X;
               end
            end
         end
         ST_DIV_X: begin
            if (rrsp.done) begin
               ddx_in = rrsp.quot;
               rreq.start = 1'b1;
               rreq.mag = it_ff.dir_y[DIR_W-1] ? DIR_W'(-it_ff.dir_y) : it_ff.dir_y;
               state_in = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (rrsp.done) begin
               ddy_in = rrsp.quot;
               state_in = ST_SIDE;
            end
         end
         ST_SIDE: begin
            sx_in = px[SIDE_W+FRAC_BITS-1:FRAC_BITS];
            sy_in = py[SIDE_W+FRAC_BITS-1:FRAC_BITS];
            state_in = (limit_ff == '0) ? ST_DONE : ST_STEP;
         end
         ST_STEP: begin
            if (go_x) begin
               dist_in = sx_ff;
               sx_in = sum_x[SIDE_W] ? SIDE_CAP : sum_x[SIDE_W-1:0];
               side_in = 1'b0;
            end else begin
               dist_in = sy_ff;
               sy_in = sum_y[SIDE_W] ? SIDE_CAP : sum_y[SIDE_W-1:0];
               side_in = 1'b1;
            end
            if (leave) begin
               state_in = ST_DONE;
            end else begin
               if (go_x) begin
                  mx_in = nx;
                  rd_addr = {my_ff, nx};
               end else begin
                  my_in = ny;
                  rd_addr = {ny, mx_ff};
               end
               cnt_in = cnt_ff + 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (rd_ff != '0) begin
               hit_in = 1'b1;
               state_in = ST_OFFS;
            end else if (cnt_ff == limit_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_OFFS: begin
            oprod_in = oprod_full[29:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               ohit_in = hit_ff;
               odata_in = {4'd0,
                           hit_ff ? osum[29:14] : 16'd0,
                           hit_ff ? dist_sat : {DIST_W{1'b0}},
                           side_ff, my_ff, mx_ff};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         limit_ff <= LIMIT_RESET;
         clr_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         limit_ff <= limit_in;
         clr_ff <= clr_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      it_ff <= it_in;
      ddx_ff <= ddx_in;
      ddy_ff <= ddy_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      dist_ff <= dist_in;
      mx_ff <= mx_in;
      my_ff <= my_in;
      side_ff <= side_in;
      hit_ff <= hit_in;
      cnt_ff <= cnt_in;
      oprod_ff <= oprod_in;
      odata_ff <= odata_in;
      ohit_ff <= ohit_in;
   end

   // map memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_ff <= map_mem[rd_addr];
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata = odata_ff;
   assign rsp_tuser = ohit_ff;

   // checks
   `DGRC_ASSERT_NOW(a_no_pop_in_clear, state_ff == ST_CLEAR, !q_pop)
   `DGRC_ASSERT_NOW(a_check_count, state_ff == ST_CHECK,
                    (cnt_ff != '0) && (cnt_ff <= limit_ff))
   `DGRC_ASSERT_NEXT(a_offs_to_done, state_ff == ST_OFFS, state_ff == ST_DONE && hit_ff)
endmodule

FILE: tb/dda_grid_ray_cast_test.sv
// testbench for the dda grid ray caster: scoreboard, stimulus and checks
`timescale 1ns / 1ps
module dda_grid_ray_cast_test;
   import dgrc_pkg::*;

   localparam longint unsigned WALK_CAP = (64'd1 << 31) - 1;
   localparam longint unsigned RANGE_MAX = (64'd1 << 23) - 1;
   localparam longint unsigned FRAC_MASK = 64'hFFFF;
   localparam int CAST_CYCLES = 700;
   localparam longint RUN_LIMIT = 5000000;
   localparam int HOLD_CYCLES = 2500;

   // one predicted cast outcome
   typedef struct packed {
      logic                hit;
      logic [MAP_BITS-1:0] col;
      logic [MAP_BITS-1:0] row;
      logic                side;
      logic [DIST_W-1:0]   perp;
      logic [OFF_W-1:0]    offset;
   } hit_report_type;

   class ray_scoreboard;
      logic [VALUE_W-1:0] grid [4096];
      logic [LIMIT_W-1:0] max_steps;
      hit_report_type     pending_hits [$];
      int                 errors;
      int                 casts_seen;
      int                 walls_seen;

      function new();
         foreach (grid[i]) grid[i] = '0;
         max_steps = LIMIT_RESET;
         errors = 0;
         casts_seen = 0;
         walls_seen = 0;
      endfunction

      // saturated reciprocal of a direction component, Q.16
      function longint unsigned step_length(int d);
         longint unsigned m, r;
         m = (d < 0) ? -d : d;
         if (m == 0) return WALK_CAP;
         r = (64'd1 << 30) / m;
         return (r > WALK_CAP) ? WALK_CAP : r;
      endfunction

      function longint unsigned first_boundary(longint unsigned p, int d,
                                               longint unsigned delta);
         longint unsigned f, r;
         f = p & FRAC_MASK;
         if (d >= 0) f = 65536 - f;
         r = (f * delta) >> 16;
         return (r > WALK_CAP) ? WALK_CAP : r;
      endfunction

      function longint unsigned capped_sum(longint unsigned a, longint unsigned b);
         longint unsigned s;
         s = a + b;
         return (s > WALK_CAP) ? WALK_CAP : s;
      endfunction

      // fractional part of pos + span*dir along the struck wall
      function longint unsigned wall_fraction(longint unsigned p, longint unsigned span,
                                              int d);
         longint unsigned dv, total;
         dv = longint'(d);
         total = (p << 14) + span * dv;
         return (total >> 14) & FRAC_MASK;
      endfunction

      // accepted input item: update the map or predict the cast
      function void note_item(item_type it);
         longint unsigned px, py, ddx, ddy, sx, sy, span, offset;
         longint mx, my, nx, ny;
         int dx, dy;
         logic side, hit;
         hit_report_type rep;
         if (it.op == OP_WRITE) begin
            grid[{it.row, it.col}] = it.value;
            return;
         end
         px = it.pos_x;
         py = it.pos_y;
         dx = it.dir_x;
         dy = it.dir_y;
         mx = px >> 16;
         my = py >> 16;
         ddx = step_length(dx);
         ddy = step_length(dy);
         sx = first_boundary(px, dx, ddx);
         sy = first_boundary(py, dy, ddy);
         span = 0;
         side = 0;
         hit = 0;
         offset = 0;
         for (int i = 0; i < max_steps; i++) begin
            nx = mx;
            ny = my;
            if (sx < sy) begin
               span = sx;
               sx = capped_sum(sx, ddx);
               nx += (dx < 0) ? -1 : 1;
               side = 0;
            end else begin
               span = sy;
               sy = capped_sum(sy, ddy);
               ny += (dy < 0) ? -1 : 1;
               side = 1;
            end
            if (nx < 0 || ny < 0 || nx >= 64 || ny >= 64) break;
            mx = nx;
            my = ny;
            if (grid[{my[5:0], mx[5:0]}] != 0) begin
               hit = 1;
               break;
            end
         end
         if (hit) begin
            offset = side ? wall_fraction(px, span, dx) : wall_fraction(py, span, dy);
            if (span > RANGE_MAX) span = RANGE_MAX;
         end else begin
            span = 0;
         end
         rep.hit = hit;
         rep.col = mx[5:0];
         rep.row = my[5:0];
         rep.side = side;
         rep.perp = span[DIST_W-1:0];
         rep.offset = offset[OFF_W-1:0];
         pending_hits.push_back(rep);
         casts_seen++;
      endfunction

      // accepted result: compare with the oldest prediction
      function void check_result(logic hit, logic [RSP_DATA_W-1:0] data);
         hit_report_type want;
         if (pending_hits.size() == 0) begin
            $display("%0t: unexpected result hit=%0d data=%h", $time, hit, data);
            errors++;
            return;
         end
         want = pending_hits.pop_front();
         if (hit) walls_seen++;
         if (hit !== want.hit) begin
            $display("%0t: hit_found expected %0d actual %0d", $time, want.hit, hit);
            errors++;
         end
         if (data[5:0] !== want.col) begin
            $display("%0t: hit_col expected %0d actual %0d", $time, want.col, data[5:0]);
            errors++;
         end
         if (data[11:6] !== want.row) begin
            $display("%0t: hit_row expected %0d actual %0d", $time, want.row, data[11:6]);
            errors++;
         end
         if (data[12] !== want.side) begin
            $display("%0t: hit_side expected %0d actual %0d", $time, want.side, data[12]);
            errors++;
         end
         if (data[35:13] !== want.perp) begin
            $display("%0t: perp_distance expected %h actual %h", $time, want.perp,
                     data[35:13]);
            errors++;
         end
         if (data[51:36] !== want.offset) begin
            $display("%0t: wall_offset expected %h actual %h", $time, want.offset,
                     data[51:36]);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we;
   logic [LIMIT_W-1:0]    csr_wdata;

   ray_scoreboard sb;
   bit      quiet;
   bit      hold_request;
   int      hold_left;
   int      stall_left;
   longint  cycle_count;

   dda_grid_ray_cast u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // accepted items go to the scoreboard
   always @(posedge clock) begin
      item_type it;
      if (!reset && req_tvalid && req_tready) begin
         it.op = op_type'(req_tuser);
         it.pos_x = req_tdata[21:0];
         it.pos_y = req_tdata[43:22];
         it.dir_x = req_tdata[59:44];
         it.dir_y = req_tdata[75:60];
         it.col = req_tdata[81:76];
         it.row = req_tdata[87:82];
         it.value = req_tdata[95:88];
         sb.note_item(it);
      end
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
   end

   // result side ready: random stall bursts, one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request <= 1'b0;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // offer one item and wait for it to be taken, then maybe idle
   task automatic send_item(item_type it);
      req_tvalid <= 1'b1;
      req_tuser <= it.op;
      req_tdata <= {it.value, it.row, it.col, it.dir_y, it.dir_x, it.pos_y, it.pos_x};
      do @(posedge clock); while (!req_tready);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic write_cell(int c, int r, int v);
      item_type it;
      it = '0;
      it.op = OP_WRITE;
      it.col = MAP_BITS'(c);
      it.row = MAP_BITS'(r);
      it.value = VALUE_W'(v);
      it.pos_x = POS_W'($urandom);
      it.pos_y = POS_W'($urandom);
      it.dir_x = DIR_W'($urandom);
      it.dir_y = DIR_W'($urandom);
      send_item(it);
   endtask

   task automatic cast_ray(int px, int py, int dx, int dy);
      item_type it;
      it.op = OP_CAST;
      it.pos_x = POS_W'(px);
      it.pos_y = POS_W'(py);
      it.dir_x = DIR_W'(dx);
      it.dir_y = DIR_W'(dy);
      it.col = MAP_BITS'($urandom);
      it.row = MAP_BITS'($urandom);
      it.value = VALUE_W'($urandom);
      send_item(it);
   endtask

   // drain outstanding results, let a trailing cast finish, then set the limit
   task automatic set_step_limit(int v);
      req_tvalid <= 1'b0;
      while (sb.pending_hits.size() > 0) @(posedge clock);
      repeat (CAST_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= LIMIT_W'(v);
      @(posedge clock);
      csr_we <= 1'b0;
      sb.max_steps = LIMIT_W'(v);
   endtask

   function automatic int random_dir();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return -32768;
         2: return 32767;
         3: return $urandom_range(0, 3) - 1;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   // mostly casts into a map that keeps gaining and losing walls
   task automatic random_items(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 30)
            write_cell($urandom_range(0, 63), $urandom_range(0, 63),
                       ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255));
         else
            cast_ray($urandom_range(0, 22'h3FFFFF), $urandom_range(0, 22'h3FFFFF),
                     random_dir(), random_dir());
      end
   endtask

   initial begin
      sb = new();
      quiet = 0;
      hold_request = 0;
      hold_left = 0;
      stall_left = 0;
      cycle_count = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: walls at corners and one inner cell, axis and diagonal rays, extremes
      write_cell(10, 10, 1);
      write_cell(0, 63, 255);
      write_cell(63, 0, 128);
      cast_ray(32'h5_8000, 32'hA_8000, 16384, 0);
      cast_ray(32'h5_8000, 32'hA_8000, 0, 0);
      cast_ray(32'h5_8000, 32'h5_8000, 16384, 16384);
      cast_ray(32'h3F_0000, 32'h1_0000, 0, -32768);
      cast_ray(22'h3FFFFF, 22'h3FFFFF, 32767, 32767);
      cast_ray(0, 0, -32768, -32768);
      cast_ray(32'h1_8000, 32'h3E_8000, -32768, 32767);
      cast_ray(32'h3E_0001, 32'h0_FFFF, 1, -1);
      cast_ray(0, 22'h3FFFFF, 32767, 0);
      write_cell(10, 10, 0);
      cast_ray(32'h5_8000, 32'hA_8000, 16384, 0);
      write_cell(63, 63, 7);
      cast_ray(32'h3E_8000, 32'h3E_8000, 16384, 16384);
      cast_ray(32'h20_1234, 32'h18_ABCD, -1, 16384);

      set_step_limit(255);
      random_items(450);
      set_step_limit(1);
      random_items(200);
      set_step_limit(3);
      random_items(200);
      set_step_limit($urandom_range(4, 254));
      random_items(300);

      // long result-side hold while casts keep coming
      set_step_limit(128);
      hold_request = 1;
      for (int n = 0; n < 40; n++)
         cast_ray($urandom_range(0, 22'h3FFFFF), $urandom_range(0, 22'h3FFFFF),
                  random_dir(), random_dir());
      random_items(200);

      // closing stretch with no idling and no random result stalls
      quiet = 1;
      random_items(240);
      req_tvalid <= 1'b0;

      while (sb.pending_hits.size() > 0) @(posedge clock);
      repeat (CAST_CYCLES) @(posedge clock);
      $display("covered %0d casts (%0d wall hits) under step limits 128, 255, 1, 3",
               sb.casts_seen, sb.walls_seen);
      $display("and one random limit, with map rewrites, stalls and a long output hold");
      if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

FILE: dda_grid_ray_cast.f
+incdir+design
design/dgrc_pkg.sv
design/dgrc_front.sv
design/dgrc_recip.sv
design/dgrc_back.sv
design/dda_grid_ray_cast.sv
tb/dda_grid_ray_cast_test.sv
